### src/akpd_pkg.sv
// Shared types, constants and register codes of the analog keypad press decoder.
package akpd_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int HOLD_BITS     = 16;
   localparam int IDLE_BITS     = 7;
   localparam int BUTTONS       = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [HOLD_BITS-1:0] IDLE_LEVEL      = HOLD_BITS'(4000);
   localparam logic [IDLE_BITS-1:0] IDLE_LIMIT      = IDLE_BITS'(100);
   localparam logic [HOLD_BITS-1:0] SHORT_HOLD_INIT = HOLD_BITS'(10);
   localparam logic [HOLD_BITS-1:0] LONG_HOLD_INIT  = HOLD_BITS'(1000);
   localparam logic [HOLD_BITS-1:0] CEILING_INIT    = HOLD_BITS'(1100);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LEVEL_ONE    = 3'd0,
      REG_LEVEL_TWO    = 3'd1,
      REG_LEVEL_THREE  = 3'd2,
      REG_TOLERANCE    = 3'd3,
      REG_SHORT_HOLD   = 3'd4,
      REG_LONG_HOLD    = 3'd5,
      REG_HOLD_CEILING = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      EVENT_NONE        = 3'd0,
      EVENT_SHORT_ONE   = 3'd1,
      EVENT_SHORT_TWO   = 3'd2,
      EVENT_SHORT_THREE = 3'd3,
      EVENT_LONG_ONE    = 3'd4,
      EVENT_LONG_TWO    = 3'd5,
      EVENT_LONG_THREE  = 3'd6
   } event_type;

   localparam event_type SHORT_EVENT [BUTTONS] =
      '{EVENT_SHORT_ONE, EVENT_SHORT_TWO, EVENT_SHORT_THREE};
   localparam event_type LONG_EVENT [BUTTONS] =
      '{EVENT_LONG_ONE, EVENT_LONG_TWO, EVENT_LONG_THREE};

   typedef struct packed {
      logic [BUTTONS-1:0][SAMPLE_BITS-1:0] levels;
      logic [SAMPLE_BITS-1:0]              tolerance;
      logic [HOLD_BITS-1:0]                short_hold;
      logic [HOLD_BITS-1:0]                long_hold;
      logic [HOLD_BITS-1:0]                hold_ceiling;
   } cfg_type;

endpackage

### src/akpd_csr.sv
// Configuration registers of the keypad decoder.
module akpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                write_en,
   input  logic [akpd_pkg::CSR_INDEX_BITS-1:0] index,
   input  logic [akpd_pkg::CSR_DATA_BITS-1:0]  data,
   output akpd_pkg::cfg_type                   cfg
);
   import akpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_index_type'(index))
            REG_LEVEL_ONE:    cfg_in.levels[0]    = data[SAMPLE_BITS-1:0];
            REG_LEVEL_TWO:    cfg_in.levels[1]    = data[SAMPLE_BITS-1:0];
            REG_LEVEL_THREE:  cfg_in.levels[2]    = data[SAMPLE_BITS-1:0];
            REG_TOLERANCE:    cfg_in.tolerance    = data[SAMPLE_BITS-1:0];
            REG_SHORT_HOLD:   cfg_in.short_hold   = data[HOLD_BITS-1:0];
            REG_LONG_HOLD:    cfg_in.long_hold    = data[HOLD_BITS-1:0];
            REG_HOLD_CEILING: cfg_in.hold_ceiling = data[HOLD_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.levels       <= '0;
         cfg_ff.tolerance    <= '0;
         cfg_ff.short_hold   <= SHORT_HOLD_INIT;
         cfg_ff.long_hold    <= LONG_HOLD_INIT;
         cfg_ff.hold_ceiling <= CEILING_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/akpd_core.sv
// Per-sample window test, hold counters, idle clearing, press flags and event priority.
module akpd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [akpd_pkg::SAMPLE_BITS-1:0] sample_a,
   input  logic [akpd_pkg::SAMPLE_BITS-1:0] sample_b,
   input  akpd_pkg::cfg_type                cfg,
   output akpd_pkg::event_type              key_event
);
   import akpd_pkg::*;

   logic [BUTTONS-1:0][HOLD_BITS-1:0] counts_ff;
   logic [BUTTONS-1:0][HOLD_BITS-1:0] counts_in;
   logic [IDLE_BITS-1:0]              idle_run_ff;
   logic [IDLE_BITS-1:0]              idle_run_in;
   logic [BUTTONS-1:0]                short_flags_ff;
   logic [BUTTONS-1:0]                short_flags_in;
   logic [BUTTONS-1:0]                long_flags_ff;
   logic [BUTTONS-1:0]                long_flags_in;

   logic [SAMPLE_BITS:0]   sum;
   logic [SAMPLE_BITS-1:0] mean;
   logic                   idle_sample;
   logic [IDLE_BITS-1:0]   idle_next;
   logic                   idle_clear;
   event_type              event_sel;

   assign sum         = {1'b0, sample_a} + {1'b0, sample_b};
   assign mean        = sum[SAMPLE_BITS:1];
   assign idle_sample = HOLD_BITS'(mean) >= IDLE_LEVEL;
   assign idle_next   = idle_sample ? idle_run_ff + 1'b1 : '0;
   assign idle_clear  = idle_next > IDLE_LIMIT;

   always_comb begin
      logic [SAMPLE_BITS:0]  upper;
      logic [SAMPLE_BITS:0]  lower_sum;
      logic [HOLD_BITS-1:0]  cnt;
      logic                  found;
      counts_in      = counts_ff;
      short_flags_in = short_flags_ff;
      long_flags_in  = long_flags_ff;
      event_sel      = EVENT_NONE;
      found          = 1'b0;
      idle_run_in    = idle_clear ? IDLE_LIMIT : idle_next;
      if (idle_clear) begin
         short_flags_in = '0;
         long_flags_in  = '0;
      end
      for (int i = 0; i < BUTTONS; i++) begin
         // Open window: level - tol < mean < level + tol, without wrap.
         upper     = {1'b0, cfg.levels[i]} + {1'b0, cfg.tolerance};
         lower_sum = {1'b0, mean} + {1'b0, cfg.tolerance};
         if (lower_sum > {1'b0, cfg.levels[i]} && {1'b0, mean} < upper) begin
            cnt = counts_ff[i] + 1'b1;
         end else begin
            cnt = '0;
         end
         if (cnt == cfg.short_hold) begin
            short_flags_in[i] = 1'b1;
            long_flags_in[i]  = 1'b0;
         end
         if (cnt == cfg.long_hold) begin
            long_flags_in[i] = 1'b1;
         end
         if (cnt > cfg.hold_ceiling) begin
            cnt = cfg.hold_ceiling;
         end
         counts_in[i] = cnt;
      end
      // A short press is reported only once the button is released.
      for (int i = 0; i < BUTTONS; i++) begin
         if (!found && short_flags_in[i] && counts_in[i] == '0) begin
            event_sel         = SHORT_EVENT[i];
            short_flags_in[i] = 1'b0;
            found             = 1'b1;
         end
      end
      for (int i = 0; i < BUTTONS; i++) begin
         if (!found && long_flags_in[i]) begin
            event_sel        = LONG_EVENT[i];
            long_flags_in[i] = 1'b0;
            found            = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff      <= '0;
         idle_run_ff    <= '0;
         short_flags_ff <= '0;
         long_flags_ff  <= '0;
      end else if (step) begin
         counts_ff      <= counts_in;
         idle_run_ff    <= idle_run_in;
         short_flags_ff <= short_flags_in;
         long_flags_ff  <= long_flags_in;
      end
   end

   assign key_event = event_sel;

`ifndef SYNTHESIS
   a_idle_bounded: assert property (@(posedge clock) disable iff (reset)
      idle_run_ff <= IDLE_LIMIT)
      else $error("idle run exceeded its limit");

   a_long_one_cleared: assert property (@(posedge clock) disable iff (reset)
      (step && key_event == EVENT_LONG_ONE) |=> !long_flags_ff[0])
      else $error("reported long press of button one left its flag set");

   a_short_needs_release: assert property (@(posedge clock) disable iff (reset)
      (step && key_event == EVENT_SHORT_ONE) |=> counts_ff[0] == '0)
      else $error("short press reported while button one still held");
`endif

endmodule

### src/analog_keypad_press_decoder.sv
// Three-button resistor-ladder keypad decoder, top level with handshake stages.
// The block takes one pair of ADC conversions per item and returns one event code per
// item: 0 none, 1-3 short press of buttons one to three (reported on release), 4-6 long
// press. It accepts one item every cycle while results are taken; an item is held in the
// input register, then in the result register on the result port. While a result
// waits to be taken, the input register can still take one more item, after which the
// input stalls until the result is taken. Configuration registers are written through the
// csr_ port, which is always ready, and should change only while no item is in flight.
module analog_keypad_press_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [akpd_pkg::SAMPLE_BITS-1:0]    req_sample_a,
   input  logic [akpd_pkg::SAMPLE_BITS-1:0]    req_sample_b,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_key_event,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [akpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [akpd_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import akpd_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [SAMPLE_BITS-1:0] in_a_ff;
   logic [SAMPLE_BITS-1:0] in_b_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [2:0]             rsp_event_ff;
   logic                   advance;
   logic                   take;
   cfg_type                cfg;
   event_type              core_event;

   akpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_valid && csr_ready),
      .index    (csr_index),
      .data     (csr_data),
      .cfg      (cfg)
   );

   akpd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .sample_a  (in_a_ff),
      .sample_b  (in_b_ff),
      .cfg       (cfg),
      .key_event (core_event)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign take         = req_valid && req_ready;
   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_a_ff <= req_sample_a;
         in_b_ff <= req_sample_b;
      end
      if (advance) begin
         rsp_event_ff <= core_event;
      end
   end

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = rsp_event_ff;

`ifndef SYNTHESIS
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      take |=> in_valid_ff)
      else $error("accepted item did not reach the input register");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach the result register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_ready)
      else $error("input register could be overwritten while stalled");
`endif

endmodule

### dv/tb_analog_keypad_press_decoder.sv
// Self-checking testbench for the three-button analog keypad press decoder.
`timescale 1ns / 100ps

module tb_analog_keypad_press_decoder;
   import akpd_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int IDLE_MEAN = 4000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_sample_a = '0;
   logic [SAMPLE_BITS-1:0]    req_sample_b = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_key_event;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   analog_keypad_press_decoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_a  (req_sample_a),
      .req_sample_b  (req_sample_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_event (rsp_key_event),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Decoder state as the testbench expects it to be.
   cfg_type              model_cfg;
   logic [HOLD_BITS-1:0] hold_cnt [BUTTONS];
   logic [IDLE_BITS-1:0] idle_streak;
   logic [BUTTONS-1:0]   short_pend;
   logic [BUTTONS-1:0]   long_pend;

   event_type pending_events [$];
   event_type expected_now;

   int  errors = 0;
   int  items_sent = 0;
   int  settings_used = 1;
   int  short_seen = 0;
   int  long_seen = 0;
   int  none_seen = 0;
   bit  gaps_on = 1'b0;
   bit  stalls_on = 1'b0;
   int  stall_left = 0;

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   function automatic event_type decode_sample(logic [SAMPLE_BITS-1:0] a,
                                               logic [SAMPLE_BITS-1:0] b);
      int        mean;
      int        lo;
      int        hi;
      event_type ev;
      mean = (int'(a) + int'(b)) >> 1;
      for (int k = 0; k < BUTTONS; k++) begin
         hold_cnt[k] = hold_cnt[k] + 16'd1;
         lo = int'(model_cfg.levels[k]) - int'(model_cfg.tolerance);
         hi = int'(model_cfg.levels[k]) + int'(model_cfg.tolerance);
         if (!(mean > lo && mean < hi)) hold_cnt[k] = '0;
      end
      if (mean >= IDLE_MEAN) idle_streak = idle_streak + 7'd1;
      else idle_streak = '0;
      // A long quiet line drops every pending press.
      if (idle_streak > IDLE_LIMIT) begin
         idle_streak = IDLE_LIMIT;
         short_pend = '0;
         long_pend = '0;
      end
      for (int k = 0; k < BUTTONS; k++) begin
         if (hold_cnt[k] == model_cfg.short_hold) begin
            short_pend[k] = 1'b1;
            long_pend[k] = 1'b0;
         end
         if (hold_cnt[k] == model_cfg.long_hold) long_pend[k] = 1'b1;
         if (hold_cnt[k] > model_cfg.hold_ceiling) hold_cnt[k] = model_cfg.hold_ceiling;
      end
      ev = EVENT_NONE;
      for (int k = 0; k < BUTTONS; k++) begin
         if (ev == EVENT_NONE && short_pend[k] && hold_cnt[k] == '0) begin
            ev = SHORT_EVENT[k];
            short_pend[k] = 1'b0;
         end
      end
      for (int k = 0; k < BUTTONS; k++) begin
         if (ev == EVENT_NONE && long_pend[k]) begin
            ev = LONG_EVENT[k];
            long_pend[k] = 1'b0;
         end
      end
      return ev;
   endfunction

   // Receiver: random stalls of mostly short length.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_ready <= 1'b0;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            errors++;
            $display("%0t: key_event with nothing outstanding: expected none, actual %0d",
                     $time, rsp_key_event);
         end else begin
            expected_now = pending_events.pop_front();
            if (rsp_key_event !== expected_now) begin
               errors++;
               $display("%0t: key_event mismatch: expected %0d, actual %0d",
                        $time, expected_now, rsp_key_event);
            end
            if (expected_now inside {EVENT_SHORT_ONE, EVENT_SHORT_TWO, EVENT_SHORT_THREE})
               short_seen++;
            else if (expected_now == EVENT_NONE) none_seen++;
            else long_seen++;
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] a,
                              input logic [SAMPLE_BITS-1:0] b);
      int pause;
      pause = gaps_on ? pick_pause() : 0;
      repeat (pause) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample_a <= a;
      req_sample_b <= b;
      do @(posedge clock); while (!req_ready);
      pending_events.push_back(decode_sample(a, b));
      items_sent++;
   endtask

   // Sends a random pair whose floored mean is m.
   task automatic send_mean(input int m);
      int s;
      int a;
      s = 2 * m + $urandom_range(0, 1);
      if (s > 8190) s = 8190;
      a = $urandom_range((s < 4095) ? s : 4095, (s > 4095) ? s - 4095 : 0);
      send_sample(SAMPLE_BITS'(a), SAMPLE_BITS'(s - a));
   endtask

   task automatic hold_button(input int k, input int n);
      int lo;
      int hi;
      lo = int'(model_cfg.levels[k]) - int'(model_cfg.tolerance) + 1;
      hi = int'(model_cfg.levels[k]) + int'(model_cfg.tolerance) - 1;
      if (lo < 0) lo = 0;
      if (hi > 4095) hi = 4095;
      repeat (n) begin
         if (lo > hi) send_mean(model_cfg.levels[k]);
         else send_mean($urandom_range(hi, lo));
      end
   endtask

   task automatic release_buttons(input int n);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) send_mean($urandom_range(IDLE_MEAN, 4095));
         else send_mean($urandom_range(3300, 3900));
      end
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_events.size() != 0) begin
         errors++;
         $display("%0t: %0d key_event results never arrived", $time, pending_events.size());
         pending_events.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_LEVEL_ONE:    model_cfg.levels[0] = data[SAMPLE_BITS-1:0];
         REG_LEVEL_TWO:    model_cfg.levels[1] = data[SAMPLE_BITS-1:0];
         REG_LEVEL_THREE:  model_cfg.levels[2] = data[SAMPLE_BITS-1:0];
         REG_TOLERANCE:    model_cfg.tolerance = data[SAMPLE_BITS-1:0];
         REG_SHORT_HOLD:   model_cfg.short_hold = data;
         REG_LONG_HOLD:    model_cfg.long_hold = data;
         REG_HOLD_CEILING: model_cfg.hold_ceiling = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int l1, input int l2, input int l3, input int tol,
                             input int sh, input int lg, input int ceil_val);
      drain_results();
      write_csr(REG_LEVEL_ONE, CSR_DATA_BITS'(l1));
      write_csr(REG_LEVEL_TWO, CSR_DATA_BITS'(l2));
      write_csr(REG_LEVEL_THREE, CSR_DATA_BITS'(l3));
      write_csr(REG_TOLERANCE, CSR_DATA_BITS'(tol));
      write_csr(REG_SHORT_HOLD, CSR_DATA_BITS'(sh));
      write_csr(REG_LONG_HOLD, CSR_DATA_BITS'(lg));
      write_csr(REG_HOLD_CEILING, CSR_DATA_BITS'(ceil_val));
      settings_used++;
   endtask

   // With the reset settings the tolerance is zero and nothing can ever be pressed.
   task automatic test_field_extremes();
      send_sample(12'h000, 12'h000);
      send_sample(12'hFFF, 12'hFFF);
      send_sample(12'hFFF, 12'h000);
      send_sample(12'h000, 12'hFFF);
      send_sample(12'hAAA, 12'h555);
      send_sample(12'h555, 12'hAAA);
      send_sample(12'h001, 12'h000);
      send_sample(12'hFFE, 12'hFFF);
   endtask

   task automatic test_register_extremes();
      // Oversized data is masked to the register width; the unused index does nothing.
      set_config(16'hFFFF, 0, 2048, 4095, 1, 2, 65534);
      write_csr(CSR_UNUSED_INDEX, 16'h1234);
      send_sample(12'hFFF, 12'hFFF);
      send_sample(12'h000, 12'h000);
      send_sample(12'h800, 12'h7FF);
      send_sample(12'hFFF, 12'h001);
      send_sample(12'h000, 12'h002);
      set_config(1000, 2000, 3000, 16'hF001, 1, 3, 5);
      send_sample(12'd1000, 12'd1000);
      send_sample(12'd1000, 12'd1001);
      send_sample(12'd1002, 12'd1000);
   endtask

   task automatic test_press_sequences();
      set_config(1000, 2000, 3000, 20, 3, 6, 8);
      hold_button(0, 9);
      release_buttons(1);
      hold_button(1, 4);
      release_buttons(1);
      hold_button(2, 7);
      release_buttons(1);
      // Overlapping windows: two counters run together, releases come out in button order.
      set_config(1000, 1010, 3000, 20, 3, 6, 8);
      send_mean(1005);
      send_mean(1005);
      send_mean(1005);
      send_mean(1005);
      release_buttons(2);
   endtask

   task automatic test_hold_extremes();
      // A zero short hold matches every released button on every sample.
      set_config(1000, 2000, 3000, 0, 0, 1000, 1100);
      release_buttons(3);
      // Ceiling below the short hold: only the long press can ever fire.
      set_config(1000, 2000, 3000, 5, 65534, 1, 1);
      hold_button(0, 4);
      release_buttons(1);
      set_config(1000, 2000, 3000, 5, 65535, 65535, 0);
      hold_button(1, 3);
      release_buttons(1);
   endtask

   task automatic test_idle_clear();
      set_config(500, 1500, 4060, 50, 5, 1000, 200);
      hold_button(2, 60);
      send_mean(3500);
      // Past a hundred quiet samples the pending press of button three is dropped.
      hold_button(2, 130);
      send_mean(3500);
      send_mean(4000);
      send_mean(3999);
   endtask

   // Ceiling at the top of the counter range: the count runs unclamped through both holds.
   task automatic test_open_ceiling();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      set_config(1000, 2000, 3000, 10, 5, 30, 65535);
      repeat (40) send_sample(12'd1000, 12'd1000);
      release_buttons(2);
   endtask

   task automatic test_random_presses();
      int tol;
      int sh;
      int lg;
      int l1;
      int l2;
      int k;
      int first_item;
      int r;
      for (int phase = 0; phase < 6; phase++) begin
         tol = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 150);
         sh = $urandom_range(1, 8);
         lg = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sh) : sh + $urandom_range(1, 30);
         l1 = $urandom_range(200, 1000);
         l2 = ($urandom_range(0, 4) == 0) ? l1 + $urandom_range(0, tol)
                                          : $urandom_range(1200, 2000);
         set_config(l1, l2, $urandom_range(2200, 3000), tol, sh, lg,
                    $urandom_range(1, lg + 20));
         gaps_on = (phase % 3) != 0;
         stalls_on = (phase % 3) != 1;
         first_item = items_sent;
         while (items_sent - first_item < 80) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, BUTTONS - 1);
            if (r < 70) begin
               hold_button(k, $urandom_range(0, lg + 5));
               release_buttons($urandom_range(1, 3));
            end else if (r < 85) begin
               send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
            end else begin
               // Slide from one button straight onto another without a release.
               hold_button(k, $urandom_range(1, lg + 2));
               hold_button((k + 1) % BUTTONS, $urandom_range(1, lg + 2));
               release_buttons(1);
            end
            if (phase == 2 && items_sent - first_item > 60 && items_sent - first_item < 70)
               drain_results();
         end
      end
   endtask

   initial begin
      model_cfg = '0;
      model_cfg.short_hold = SHORT_HOLD_INIT;
      model_cfg.long_hold = LONG_HOLD_INIT;
      model_cfg.hold_ceiling = CEILING_INIT;
      for (int k = 0; k < BUTTONS; k++) hold_cnt[k] = '0;
      idle_streak = '0;
      short_pend = '0;
      long_pend = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_register_extremes();
      test_press_sequences();
      test_hold_extremes();
      test_idle_clear();
      test_open_ceiling();
      test_random_presses();
      drain_results();

      $display("Sent %0d samples across %0d register settings with random gaps and stalls.",
               items_sent, settings_used);
      $display("Decoded %0d short presses, %0d long presses and %0d quiet samples.",
               short_seen, long_seen, none_seen);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Run did not finish in time.");
      $display("TB_ERROR");
      $finish;
   end

endmodule

### analog_keypad_press_decoder.f
src/akpd_pkg.sv
src/akpd_csr.sv
src/akpd_core.sv
src/analog_keypad_press_decoder.sv
dv/tb_analog_keypad_press_decoder.sv
